@@ rtl/core/fifo_queue_with_delete_macros.svh @@
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_macros.svh
// Assertion macros used by the queue RTL.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_DELETE_MACROS_SVH
`define FIFO_QUEUE_WITH_DELETE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FQD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("fifo_queue_with_delete: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define FQD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("fifo_queue_with_delete: next-cycle check failed");

`endif

@@ rtl/core/fqd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared types and constants of the handle queue with delete.
// ----------------------------------------------------------------------------
package fqd_pkg;

	// Defaults for the top-level parameters
	localparam int DEPTH_DEF       = 16;
	localparam int HANDLE_BITS_DEF = 32;

	// Fixed field widths on the ports
	localparam int KIND_W         = 2;
	localparam int HANDLE_FIELD_W = 32;
	localparam int FILL_W         = 5;
	localparam int S_TDATA_W      = 32;
	localparam int S_TUSER_W      = 2;
	localparam int M_TDATA_W      = 40;

	// Request kind codes as they arrive on the port
	localparam logic [KIND_W-1:0] KIND_ENQ = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEQ = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DEL = 2'd2;

	// Classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_ENQ,
		OP_DEQ,
		OP_DEL,
		OP_BAD
	} op_t;

	localparam int OP_W = $bits(op_t);

	// Back-end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEQ,
		ST_SEARCH,
		ST_SHIFT
	} state_t;

endpackage

@@ rtl/core/fqd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_front
// Accepts request beats and classifies them into queue operations.
// ----------------------------------------------------------------------------
module fqd_front #(
	parameter int HANDLE_BITS = fqd_pkg::HANDLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [fqd_pkg::S_TDATA_W-1:0]       s_tdata,   // [31:0] handle_in
	input  logic [fqd_pkg::S_TUSER_W-1:0]       s_tuser,   // [1:0] kind
	output logic                                push_valid,
	input  logic                                push_ready,
	output logic [fqd_pkg::OP_W+HANDLE_BITS-1:0] push_data
);

	logic                   vld_s1;
	fqd_pkg::op_t           op_s1;
	logic [HANDLE_BITS-1:0] hnd_s1;
	fqd_pkg::op_t           op_cls;
	logic [HANDLE_BITS-1:0] hnd_in;
	logic                   hnd_null;

	// Take the handle at the stored width
	assign hnd_in   = HANDLE_BITS'(s_tdata[fqd_pkg::HANDLE_FIELD_W-1:0]);
	assign hnd_null = (hnd_in == '0);

	// Classify the request; null enqueue or delete handles and unknown kinds become errors
	always_comb begin
		unique case (s_tuser[fqd_pkg::KIND_W-1:0])
			fqd_pkg::KIND_ENQ: op_cls = hnd_null ? fqd_pkg::OP_BAD : fqd_pkg::OP_ENQ;
			fqd_pkg::KIND_DEQ: op_cls = fqd_pkg::OP_DEQ;
			fqd_pkg::KIND_DEL: op_cls = hnd_null ? fqd_pkg::OP_BAD : fqd_pkg::OP_DEL;
			default:           op_cls = fqd_pkg::OP_BAD;
		endcase
	end

	// Hold one classified beat until the command queue takes it
	assign s_tready   = !vld_s1 || push_ready;
	assign push_valid = vld_s1;
	assign push_data  = {op_s1, hnd_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= op_cls;
			hnd_s1 <= hnd_in;
		end
	end

endmodule

@@ rtl/core/fqd_cmd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_cmd_queue
// Two-entry command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module fqd_cmd_queue #(
	parameter int WIDTH = fqd_pkg::OP_W + fqd_pkg::HANDLE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] ent_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = ent_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Store the pushed beat
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/core/fqd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_back
// Executes queue operations on the slot memory and registers each result.
// ----------------------------------------------------------------------------
module fqd_back #(
	parameter int DEPTH       = fqd_pkg::DEPTH_DEF,
	parameter int HANDLE_BITS = fqd_pkg::HANDLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	output logic                                 cmd_ready,
	input  logic [fqd_pkg::OP_W+HANDLE_BITS-1:0] cmd_data,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [fqd_pkg::M_TDATA_W-1:0]        m_tdata    // [0] status,
	                                                         // [32:1] handle_out,
	                                                         // [37:33] fill_count
);

	localparam int IW = $clog2(DEPTH);
	localparam int OW = $clog2(DEPTH + 1);
	localparam int PAD_W = fqd_pkg::M_TDATA_W - 1 - fqd_pkg::HANDLE_FIELD_W - fqd_pkg::FILL_W;

	fqd_pkg::state_t state_q;
	fqd_pkg::state_t state_d;

	logic [IW-1:0]          head_q;
	logic [OW-1:0]          occ_q;
	logic [HANDLE_BITS-1:0] hnd_q;
	logic [OW-1:0]          idx_q;
	logic [OW-1:0]          idx_d;
	logic                   rd_vld_s1;
	logic                   rd_vld_d;
	logic [OW-1:0]          rd_pos_s1;
	logic [OW-1:0]          rd_pos_d;
	logic [HANDLE_BITS-1:0] rdata_s1;

	logic [HANDLE_BITS-1:0] mem [DEPTH];

	fqd_pkg::op_t           cmd_op;
	logic [HANDLE_BITS-1:0] cmd_hnd;
	logic                   out_free;
	logic                   pop;
	logic                   match;
	logic                   more;
	logic                   scan_end;
	logic                   not_full;
	logic                   not_empty;

	logic                   rd_en;
	logic [IW-1:0]          rd_addr;
	logic                   wr_en;
	logic [IW-1:0]          wr_addr;
	logic [HANDLE_BITS-1:0] wr_data;
	logic                   head_adv;
	logic                   occ_inc;
	logic                   occ_dec;
	logic                   res_load;
	logic                   res_status;
	logic [HANDLE_BITS-1:0] res_handle;
	logic [OW-1:0]          res_fill;

	logic                              out_valid_q;
	logic                              out_status_q;
	logic [fqd_pkg::HANDLE_FIELD_W-1:0] out_handle_q;
	logic [fqd_pkg::FILL_W-1:0]        out_fill_q;

	// Ring position of an offset from the head; the sum stays below twice DEPTH
	function automatic logic [IW-1:0] slot_at(input logic [IW-1:0] head,
	                                          input logic [OW-1:0] off);
		logic [OW:0] sum;
		begin
			sum = (OW+1)'(head) + (OW+1)'(off);
			if (sum >= (OW+1)'(DEPTH)) begin
				sum = sum - (OW+1)'(DEPTH);
			end
			return IW'(sum);
		end
	endfunction

	assign cmd_op    = fqd_pkg::op_t'(cmd_data[fqd_pkg::OP_W+HANDLE_BITS-1:HANDLE_BITS]);
	assign cmd_hnd   = cmd_data[HANDLE_BITS-1:0];
	assign out_free  = !out_valid_q || m_tready;
	assign pop       = cmd_valid && (state_q == fqd_pkg::ST_IDLE) && out_free;
	assign cmd_ready = (state_q == fqd_pkg::ST_IDLE) && out_free;
	assign match     = rd_vld_s1 && (rdata_s1 == hnd_q);
	assign more      = (idx_q < occ_q);
	assign scan_end  = !rd_vld_s1 && !more;
	assign not_full  = (occ_q < OW'(DEPTH));
	assign not_empty = (occ_q != '0);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fqd_pkg::ST_IDLE: begin
				if (pop) begin
					if (cmd_op == fqd_pkg::OP_DEQ && not_empty) begin
						state_d = fqd_pkg::ST_DEQ;
					end else if (cmd_op == fqd_pkg::OP_DEL) begin
						state_d = fqd_pkg::ST_SEARCH;
					end
				end
			end
			fqd_pkg::ST_DEQ: begin
				state_d = fqd_pkg::ST_IDLE;
			end
			fqd_pkg::ST_SEARCH: begin
				if (match) begin
					state_d = fqd_pkg::ST_SHIFT;
				end else if (scan_end) begin
					state_d = fqd_pkg::ST_IDLE;
				end
			end
			fqd_pkg::ST_SHIFT: begin
				if (scan_end) begin
					state_d = fqd_pkg::ST_IDLE;
				end
			end
			default: state_d = fqd_pkg::ST_IDLE;
		endcase
	end

	// Datapath control per state
	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = slot_at(head_q, idx_q);
		wr_en      = 1'b0;
		wr_addr    = slot_at(head_q, occ_q);
		wr_data    = cmd_hnd;
		head_adv   = 1'b0;
		occ_inc    = 1'b0;
		occ_dec    = 1'b0;
		res_load   = 1'b0;
		res_status = 1'b1;
		res_handle = '0;
		res_fill   = occ_q;
		idx_d      = idx_q;
		rd_vld_d   = 1'b0;
		rd_pos_d   = rd_pos_s1;
		unique case (state_q)
			fqd_pkg::ST_IDLE: begin
				idx_d = '0;
				if (pop) begin
					unique case (cmd_op)
						fqd_pkg::OP_ENQ: begin
							res_load = 1'b1;
							if (not_full) begin
								wr_en      = 1'b1;
								occ_inc    = 1'b1;
								res_status = 1'b0;
								res_fill   = occ_q + OW'(1);
							end
						end
						fqd_pkg::OP_DEQ: begin
							if (not_empty) begin
								rd_en   = 1'b1;
								rd_addr = head_q;
							end else begin
								res_load = 1'b1;
							end
						end
						fqd_pkg::OP_DEL: begin
							res_load = 1'b0;
						end
						fqd_pkg::OP_BAD: begin
							res_load = 1'b1;
						end
						default: res_load = 1'b1;
					endcase
				end
			end
			fqd_pkg::ST_DEQ: begin
				head_adv   = 1'b1;
				occ_dec    = 1'b1;
				res_load   = 1'b1;
				res_status = 1'b0;
				res_handle = rdata_s1;
				res_fill   = occ_q - OW'(1);
			end
			fqd_pkg::ST_SEARCH: begin
				// Stream reads one slot a cycle and compare each in the cycle after its read
				if (more) begin
					rd_en    = 1'b1;
					rd_vld_d = 1'b1;
					rd_pos_d = idx_q;
					idx_d    = idx_q + OW'(1);
				end
				if (match) begin
					rd_en    = 1'b0;
					rd_vld_d = 1'b0;
					idx_d    = rd_pos_s1 + OW'(1);
				end else if (scan_end) begin
					res_load = 1'b1;
				end
			end
			fqd_pkg::ST_SHIFT: begin
				// Read the next slot and write the previous one a place earlier
				if (more) begin
					rd_en    = 1'b1;
					rd_vld_d = 1'b1;
					rd_pos_d = idx_q;
					idx_d    = idx_q + OW'(1);
				end
				if (rd_vld_s1) begin
					wr_en   = 1'b1;
					wr_addr = slot_at(head_q, rd_pos_s1 - OW'(1));
					wr_data = rdata_s1;
				end
				if (scan_end) begin
					occ_dec    = 1'b1;
					res_load   = 1'b1;
					res_status = 1'b0;
					res_fill   = occ_q - OW'(1);
				end
			end
			default: res_load = 1'b0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fqd_pkg::ST_IDLE;
			head_q      <= '0;
			occ_q       <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			rd_vld_s1 <= rd_vld_d;
			if (head_adv) begin
				head_q <= (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);
			end
			if (occ_inc) begin
				occ_q <= occ_q + OW'(1);
			end else if (occ_dec) begin
				occ_q <= occ_q - OW'(1);
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		rd_pos_s1 <= rd_pos_d;
		if (pop) begin
			hnd_q <= cmd_hnd;
		end
		if (res_load) begin
			out_status_q <= res_status;
			out_handle_q <= fqd_pkg::HANDLE_FIELD_W'(res_handle);
			out_fill_q   <= fqd_pkg::FILL_W'(res_fill);
		end
	end

	// Slot memory: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_fill_q, out_handle_q, out_status_q};

endmodule

@@ rtl/core/fifo_queue_with_delete.sv @@
`timescale 1ns / 1ps
// Path: a request beat is registered in the front, queued in the command queue, then executed;
// enqueue and error results load on issue, dequeue results after the head slot read.
// Throughput: one enqueue or error a cycle while results drain; a dequeue or delete holds
// the executor, a delete reading one slot a cycle to find the match and close the gap.
// Reset: arst_n clears the queue to empty; slot contents are not cleared.
// ----------------------------------------------------------------------------
// fifo_queue_with_delete
// Bounded FIFO of nonzero handles with enqueue, dequeue and delete by value.
// ----------------------------------------------------------------------------
`include "fifo_queue_with_delete_macros.svh"

module fifo_queue_with_delete #(
	parameter int DEPTH       = fqd_pkg::DEPTH_DEF,
	parameter int HANDLE_BITS = fqd_pkg::HANDLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fqd_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] handle_in
	input  logic [fqd_pkg::S_TUSER_W-1:0] s_tuser,   // [1:0] kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fqd_pkg::M_TDATA_W-1:0] m_tdata    // [0] status, [32:1] handle_out,
	                                                 // [37:33] fill_count
);

	localparam int CMD_W = fqd_pkg::OP_W + HANDLE_BITS;

	logic             push_valid;
	logic             push_ready;
	logic [CMD_W-1:0] push_data;
	logic             cmd_valid;
	logic             cmd_ready;
	logic [CMD_W-1:0] cmd_data;

	// Accept and classify
	fqd_front #(
		.HANDLE_BITS(HANDLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	// Decouple front and back
	fqd_cmd_queue #(
		.WIDTH(CMD_W)
	) u_cmd_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (cmd_valid),
		.pop_ready (cmd_ready),
		.pop_data  (cmd_data)
	);

	// Execute on the slot memory
	fqd_back #(
		.DEPTH      (DEPTH),
		.HANDLE_BITS(HANDLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_data (cmd_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Reported length never exceeds the capacity
	`FQD_ASSERT_NOW(a_fill_bound, clk, arst_n, m_tvalid, (32'(m_tdata[37:33]) <= 32'(DEPTH)) || (DEPTH >= 32))

	// Error results carry no handle
	`FQD_ASSERT_NOW(a_err_no_handle, clk, arst_n, m_tvalid && m_tdata[0], m_tdata[32:1] == '0)

	// A command is taken only when the result slot can hold its result
	`FQD_ASSERT_NOW(a_pop_out_free, clk, arst_n, cmd_valid && cmd_ready, !m_tvalid || m_tready)

	// A stalled result beat keeps its payload
	`FQD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the handle queue with enqueue, dequeue and delete.
// Requests are driven as stream beats and mirrored into a software queue that
// predicts status, dequeued handle and fill level. Every response beat is
// checked in order against that prediction. Directed corner cases come first.
// Random traffic follows under several sender and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CLK_PERIOD    = 8;
	localparam int QUEUE_DEPTH   = fqd_pkg::DEPTH_DEF;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 2 * fqd_pkg::DEPTH_DEF + 12;
	localparam int PHASE_ITEMS   = 430;
	localparam int HW            = fqd_pkg::HANDLE_FIELD_W;

	// Kind code with no operation behind it
	localparam logic [fqd_pkg::KIND_W-1:0] KIND_BAD = 2'd3;

	// Response field positions in m_tdata
	localparam int STATUS_BIT = 0;
	localparam int HANDLE_LSB = 1;
	localparam int FILL_LSB   = HANDLE_LSB + HW;

	typedef struct packed {
		logic                       status;
		logic [HW-1:0]              handle_out;
		logic [fqd_pkg::FILL_W-1:0] fill_count;
	} reply_t;

	logic                          clk;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [fqd_pkg::S_TDATA_W-1:0] s_tdata  = '0;
	logic [fqd_pkg::S_TUSER_W-1:0] s_tuser  = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [fqd_pkg::M_TDATA_W-1:0] m_tdata;

	// Shadow of the queue contents, oldest entry first
	logic [HW-1:0] model_entries[$];
	// Predicted responses still owed by the block
	reply_t        pending_replies[$];

	logic [HW-1:0] handle_pool [8] = '{
		32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_00A5,
		32'h5A5A_5A5A, 32'h0000_1000, 32'h7FFF_FFFF, 32'hDEAD_0001
	};

	int err_count      = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_count    = 0;

	fifo_queue_with_delete DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [31:0] handle_in
		.s_tuser  (s_tuser),   // [1:0] kind
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // [0] status, [32:1] handle_out, [37:33] fill_count
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Apply one request to the shadow queue and return the response it owes
	function automatic reply_t queue_model_apply(input logic [fqd_pkg::KIND_W-1:0] kind,
			input logic [HW-1:0] handle);
		reply_t r;
		int     hit;
		int     i;
		r.status     = 1'b1;
		r.handle_out = '0;
		hit          = -1;
		case (kind)
			fqd_pkg::KIND_ENQ: begin
				if (handle != '0 && model_entries.size() < QUEUE_DEPTH) begin
					model_entries.push_back(handle);
					r.status = 1'b0;
				end
			end
			fqd_pkg::KIND_DEQ: begin
				if (model_entries.size() > 0) begin
					r.handle_out = model_entries.pop_front();
					r.status     = 1'b0;
				end
			end
			fqd_pkg::KIND_DEL: begin
				// Remove only the oldest match; the rest keep their order
				if (handle != '0) begin
					for (i = 0; i < model_entries.size() && hit < 0; i++)
						if (model_entries[i] == handle)
							hit = i;
					if (hit >= 0) begin
						model_entries.delete(hit);
						r.status = 1'b0;
					end
				end
			end
			default: ;
		endcase
		r.fill_count = fqd_pkg::FILL_W'(model_entries.size());
		return r;
	endfunction

	// Drive one request beat and hold it until the block takes it
	task automatic send_request(input logic [fqd_pkg::KIND_W-1:0] kind,
			input logic [HW-1:0] handle);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= handle;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_replies.push_back(queue_model_apply(kind, handle));
	endtask

	// Stop sending and hold off until every owed response has arrived
	task automatic wait_until_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [HW-1:0] pick_handle();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return handle_pool[3'($urandom_range(7))];
		else if (r < 90)
			return $urandom;
		else if (r < 95)
			return '0;
		else
			return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0001;
	endfunction

	task automatic report_field(input string name, input logic [HW-1:0] want,
			input logic [HW-1:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	task automatic check_reply(input logic [fqd_pkg::M_TDATA_W-1:0] beat);
		reply_t want;
		if (pending_replies.size() == 0) begin
			err_count++;
			$display("%0t: unexpected response, expected none, actual 0x%0h", $time, beat);
		end else begin
			want = pending_replies.pop_front();
			report_field("status", HW'(want.status), HW'(beat[STATUS_BIT]));
			report_field("handle_out", want.handle_out, beat[HANDLE_LSB +: HW]);
			report_field("fill_count", HW'(want.fill_count),
				HW'(beat[FILL_LSB +: fqd_pkg::FILL_W]));
		end
	endtask

	// Stall the response side at random
	initial begin
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check each accepted response beat
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			check_reply(m_tdata);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Errors on an empty queue, null handles, unknown kind, full queue, duplicates
	task automatic test_directed_cases();
		int i;
		logic [HW-1:0] h;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_request(fqd_pkg::KIND_DEQ, 32'h0);
		send_request(fqd_pkg::KIND_DEL, 32'h0000_0005);
		send_request(fqd_pkg::KIND_ENQ, 32'h0);
		send_request(fqd_pkg::KIND_DEL, 32'h0);
		send_request(KIND_BAD, 32'hFFFF_FFFF);
		for (i = 0; i < QUEUE_DEPTH; i++) begin
			case (i)
				0, 5:    h = 32'hFFFF_FFFF;
				1:       h = 32'h0000_0001;
				2:       h = 32'h8000_0000;
				default: h = 32'h0000_1000 + i;
			endcase
			send_request(fqd_pkg::KIND_ENQ, h);
		end
		send_request(fqd_pkg::KIND_ENQ, 32'h0000_0007);
		send_request(fqd_pkg::KIND_DEL, 32'hFFFF_FFFF);
		send_request(fqd_pkg::KIND_DEL, 32'h0000_1000 + QUEUE_DEPTH - 1);
		send_request(fqd_pkg::KIND_DEL, 32'h1234_5678);
		send_request(fqd_pkg::KIND_DEQ, 32'hFFFF_FFFF);
		wait_until_drained();
	endtask

	// Random traffic that sweeps the fill level up and down
	task automatic test_random_traffic(input int count, input int idle_pct,
			input int stall_pct);
		int i;
		int r;
		int fill_target;
		logic [fqd_pkg::KIND_W-1:0] kind;
		logic [HW-1:0]              handle;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		fill_target    = QUEUE_DEPTH;
		for (i = 0; i < count; i++) begin
			if (i % 24 == 23)
				fill_target = $urandom_range(QUEUE_DEPTH);
			r = $urandom_range(99);
			if (model_entries.size() <= fill_target)
				kind = (r < 55) ? fqd_pkg::KIND_ENQ : (r < 75) ? fqd_pkg::KIND_DEL :
					(r < 97) ? fqd_pkg::KIND_DEQ : KIND_BAD;
			else
				kind = (r < 25) ? fqd_pkg::KIND_ENQ : (r < 55) ? fqd_pkg::KIND_DEL :
					(r < 97) ? fqd_pkg::KIND_DEQ : KIND_BAD;
			// Mostly delete handles that are present
			if (kind == fqd_pkg::KIND_DEL && model_entries.size() > 0 &&
					$urandom_range(99) < 85)
				handle = model_entries[$urandom_range(model_entries.size() - 1)];
			else if (kind == fqd_pkg::KIND_DEQ || kind == KIND_BAD)
				handle = $urandom;
			else
				handle = pick_handle();
			send_request(kind, handle);
			if ($urandom_range(149) == 0)
				wait_until_drained();
		end
		wait_until_drained();
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_random_traffic(PHASE_ITEMS, 0, 0);
		test_random_traffic(PHASE_ITEMS, 85, 0);
		test_random_traffic(PHASE_ITEMS, 0, 85);
		test_random_traffic(PHASE_ITEMS, 28, 28);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0 && pending_replies.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
